[rtl/core/dsf_pkg.sv]
// Package for the damped spring follower: lanes, micro-ops, control structs
// and the microcode ROM contents. No dependencies.
package dsf_pkg;

   localparam int WORD_W             = 32;
   localparam int TGT_W              = 20;
   localparam int SCALE_W            = 16;
   localparam int PIX_W              = 12;
   localparam int FRAC_BITS          = 8;
   localparam int GAIN_W             = 4;
   localparam int LANES              = 4;
   localparam int LANE_W             = 2;
   localparam int STEP_W             = 5;
   localparam int DIV_SHIFT          = 3;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 4'd1;
   localparam logic [WORD_W-1:0]  SCALE_RESET = 32'd256;

   localparam int SNAP_THRESHOLD_DEF = 4;
   localparam int DAMP_NUMERATOR_DEF = 179;
   localparam int DAMP_SHIFT_DEF     = 8;

   typedef enum logic [LANE_W-1:0] {
      LANE_X = 2'd0,
      LANE_Y = 2'd1,
      LANE_S = 2'd2,
      LANE_R = 2'd3
   } lane_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_ERR,
      OP_ACC,
      OP_SNAP,
      OP_DAMP,
      OP_MOVE,
      OP_DONE
   } op_type;

   typedef enum logic [2:0] {
      C_NONE,
      C_ALWAYS,
      C_REST,
      C_BIG_XY,
      C_BIG_LANE
   } cond_type;

   typedef struct packed {
      op_type            op;
      lane_type          lane;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic     load;
      op_type   op;
      lane_type lane;
   } ctrl_type;

   typedef struct packed {
      logic rest;
      logic big_xy;
      logic big_lane;
   } status_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_x;
      logic [PIX_W-1:0]   pixel_y;
      logic [SCALE_W-1:0] scale_now;
      logic [SCALE_W-1:0] angle_now;
      logic               settled;
   } result_type;

   localparam logic [STEP_W-1:0] STEP_DAMP_XY = 5'd12;
   localparam logic [STEP_W-1:0] STEP_SCALE   = 5'd16;
   localparam logic [STEP_W-1:0] STEP_DAMP_S  = 5'd18;
   localparam logic [STEP_W-1:0] STEP_ROT     = 5'd20;
   localparam logic [STEP_W-1:0] STEP_DAMP_R  = 5'd22;
   localparam logic [STEP_W-1:0] STEP_DONE    = 5'd24;
   localparam logic [STEP_W-1:0] STEP_NONE    = 5'd0;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         5'd0:    w = '{OP_NOP,  LANE_X, C_REST,     STEP_DONE};
         5'd1:    w = '{OP_ERR,  LANE_X, C_NONE,     STEP_NONE};
         5'd2:    w = '{OP_ACC,  LANE_X, C_NONE,     STEP_NONE};
         5'd3:    w = '{OP_ERR,  LANE_Y, C_NONE,     STEP_NONE};
         5'd4:    w = '{OP_ACC,  LANE_Y, C_NONE,     STEP_NONE};
         5'd5:    w = '{OP_ERR,  LANE_S, C_NONE,     STEP_NONE};
         5'd6:    w = '{OP_ACC,  LANE_S, C_NONE,     STEP_NONE};
         5'd7:    w = '{OP_ERR,  LANE_R, C_NONE,     STEP_NONE};
         5'd8:    w = '{OP_ACC,  LANE_R, C_NONE,     STEP_NONE};
         5'd9:    w = '{OP_NOP,  LANE_X, C_BIG_XY,   STEP_DAMP_XY};
         5'd10:   w = '{OP_SNAP, LANE_X, C_NONE,     STEP_NONE};
         5'd11:   w = '{OP_SNAP, LANE_Y, C_ALWAYS,   STEP_SCALE};
         5'd12:   w = '{OP_DAMP, LANE_X, C_NONE,     STEP_NONE};
         5'd13:   w = '{OP_MOVE, LANE_X, C_NONE,     STEP_NONE};
         5'd14:   w = '{OP_DAMP, LANE_Y, C_NONE,     STEP_NONE};
         5'd15:   w = '{OP_MOVE, LANE_Y, C_NONE,     STEP_NONE};
         5'd16:   w = '{OP_NOP,  LANE_S, C_BIG_LANE, STEP_DAMP_S};
         5'd17:   w = '{OP_SNAP, LANE_S, C_ALWAYS,   STEP_ROT};
         5'd18:   w = '{OP_DAMP, LANE_S, C_NONE,     STEP_NONE};
         5'd19:   w = '{OP_MOVE, LANE_S, C_NONE,     STEP_NONE};
         5'd20:   w = '{OP_NOP,  LANE_R, C_BIG_LANE, STEP_DAMP_R};
         5'd21:   w = '{OP_SNAP, LANE_R, C_ALWAYS,   STEP_DONE};
         5'd22:   w = '{OP_DAMP, LANE_R, C_NONE,     STEP_NONE};
         5'd23:   w = '{OP_MOVE, LANE_R, C_NONE,     STEP_NONE};
         default: w = '{OP_DONE, LANE_X, C_NONE,     STEP_NONE};
      endcase
      return w;
   endfunction

endpackage

[rtl/core/dsf_sequencer.sv]
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
// Depends on dsf_pkg.
module dsf_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  out_free,
   output logic                  out_load,
   input  dsf_pkg::status_type   status,
   output dsf_pkg::ctrl_type     ctrl
);
   import dsf_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_RUN
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         word;
   logic              jump;

   assign word      = ucode_rom(step_ff);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      unique case (word.cond)
         C_NONE:     jump = 1'b0;
         C_ALWAYS:   jump = 1'b1;
         C_REST:     jump = status.rest;
         C_BIG_XY:   jump = status.big_xy;
         C_BIG_LANE: jump = status.big_lane;
         default:    jump = 1'b0;
      endcase
   end

   always_comb begin
      ctrl.load = req_valid && (state_ff == S_IDLE);
      ctrl.op   = (state_ff == S_RUN) ? word.op : OP_NOP;
      ctrl.lane = word.lane;
      out_load  = (state_ff == S_RUN) && (word.op == OP_DONE) && out_free;
      state_in  = state_ff;
      step_in   = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RUN;
               step_in  = '0;
            end
         end
         S_RUN: begin
            if (word.op == OP_DONE) begin
               if (out_free) begin
                  state_in = S_IDLE;
               end
            end else if (jump) begin
               step_in = word.target;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

[rtl/core/dsf_datapath.sv]
// Datapath: state registers per lane, target latch and one shared ALU.
// Depends on dsf_pkg; driven by dsf_sequencer control words.
module dsf_datapath #(
   parameter int SNAP_THRESHOLD = dsf_pkg::SNAP_THRESHOLD_DEF,
   parameter int DAMP_NUMERATOR = dsf_pkg::DAMP_NUMERATOR_DEF,
   parameter int DAMP_SHIFT     = dsf_pkg::DAMP_SHIFT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dsf_pkg::ctrl_type                   ctrl,
   input  logic [dsf_pkg::GAIN_W-1:0]          speed_gain,
   input  logic signed [dsf_pkg::TGT_W-1:0]    target_x,
   input  logic signed [dsf_pkg::TGT_W-1:0]    target_y,
   input  logic [dsf_pkg::SCALE_W-1:0]         target_scale,
   input  logic signed [dsf_pkg::TGT_W-1:0]    target_rotation,
   output dsf_pkg::status_type                 status,
   output dsf_pkg::result_type                 result
);
   import dsf_pkg::*;

   localparam logic [WORD_W-1:0] SNAP_LIM  = WORD_W'(SNAP_THRESHOLD);
   localparam logic [WORD_W-1:0] DAMP_MUL  = WORD_W'(DAMP_NUMERATOR);
   localparam logic [WORD_W-1:0] DAMP_RND  = WORD_W'(1) << (DAMP_SHIFT - 1);

   logic [WORD_W-1:0] val_ff [LANES];
   logic [WORD_W-1:0] val_in [LANES];
   logic [WORD_W-1:0] vel_ff [LANES];
   logic [WORD_W-1:0] vel_in [LANES];
   logic [WORD_W-1:0] tgt_ff [LANES];
   logic [WORD_W-1:0] tgt_in [LANES];
   logic [WORD_W-1:0] tmp_ff, tmp_in;

   logic [WORD_W-1:0] lval, lvel, ltgt, diff, damp_sum, angle;
   logic [GAIN_W-1:0] gain_sel;

   function automatic logic [WORD_W-1:0] div8(input logic [WORD_W-1:0] u);
      logic [WORD_W-1:0] r;
      if (u[WORD_W-1]) begin
         r = '0 - (('0 - u) >> DIV_SHIFT);
      end else begin
         r = u >> DIV_SHIFT;
      end
      return r;
   endfunction

   function automatic logic is_small(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] mag;
      mag = v[WORD_W-1] ? ('0 - v) : v;
      return mag < SNAP_LIM;
   endfunction

   assign lval     = val_ff[ctrl.lane];
   assign lvel     = vel_ff[ctrl.lane];
   assign ltgt     = tgt_ff[ctrl.lane];
   assign diff     = ltgt - lval;
   assign gain_sel = (ctrl.lane == LANE_X || ctrl.lane == LANE_Y) ? speed_gain : GAIN_W'(1);
   assign damp_sum = lvel * DAMP_MUL + DAMP_RND;

   always_comb begin
      val_in = val_ff;
      vel_in = vel_ff;
      tgt_in = tgt_ff;
      tmp_in = tmp_ff;
      if (ctrl.load) begin
         tgt_in[LANE_X] = WORD_W'(target_x);
         tgt_in[LANE_Y] = WORD_W'(target_y);
         tgt_in[LANE_S] = {{(WORD_W-SCALE_W){1'b0}}, target_scale};
         tgt_in[LANE_R] = WORD_W'(target_rotation);
      end
      case (ctrl.op)
         OP_ERR:  tmp_in = diff * {{(WORD_W-GAIN_W){1'b0}}, gain_sel};
         OP_ACC:  vel_in[ctrl.lane] = lvel + div8(tmp_ff);
         OP_SNAP: begin
            vel_in[ctrl.lane] = '0;
            val_in[ctrl.lane] = ltgt;
         end
         OP_DAMP: vel_in[ctrl.lane] = WORD_W'($signed(damp_sum) >>> DAMP_SHIFT);
         OP_MOVE: val_in[ctrl.lane] = lval + lvel;
         default: ;
      endcase
   end

   always_comb begin
      status.rest = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         if (vel_ff[i] != '0 || val_ff[i] != tgt_ff[i]) begin
            status.rest = 1'b0;
         end
      end
      status.big_xy   = !(is_small(vel_ff[LANE_X]) && is_small(vel_ff[LANE_Y]));
      status.big_lane = !is_small(lvel);
   end

   assign angle            = val_ff[LANE_R] - vel_ff[LANE_X];
   assign result.pixel_x   = val_ff[LANE_X][FRAC_BITS +: PIX_W];
   assign result.pixel_y   = val_ff[LANE_Y][FRAC_BITS +: PIX_W];
   assign result.scale_now = val_ff[LANE_S][SCALE_W-1:0];
   assign result.angle_now = angle[SCALE_W-1:0];
   assign result.settled   = status.rest;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) begin
            val_ff[i] <= (i == int'(LANE_S)) ? SCALE_RESET : '0;
            vel_ff[i] <= '0;
         end
      end else begin
         val_ff <= val_in;
         vel_ff <= vel_in;
      end
      tgt_ff <= tgt_in;
      tmp_ff <= tmp_in;
   end

endmodule

[rtl/core/damped_spring_follower_top.sv]
// Throughput: one transaction at a time, taken the cycle after the previous result enters
// the output register, and later while a stalled receiver holds the output register full.
// Reset (synchronous, active high): state cleared, scale to one (256), gain to 1.
// Top level of the damped spring follower: config register, output register.
// Depends on dsf_pkg, dsf_sequencer and dsf_datapath.
module damped_spring_follower_top #(
   parameter int SNAP_THRESHOLD = dsf_pkg::SNAP_THRESHOLD_DEF,
   parameter int DAMP_NUMERATOR = dsf_pkg::DAMP_NUMERATOR_DEF,
   parameter int DAMP_SHIFT     = dsf_pkg::DAMP_SHIFT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dsf_pkg::GAIN_W-1:0]        csr_speed_gain,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [dsf_pkg::TGT_W-1:0]  req_target_x,
   input  logic signed [dsf_pkg::TGT_W-1:0]  req_target_y,
   input  logic [dsf_pkg::SCALE_W-1:0]       req_target_scale,
   input  logic signed [dsf_pkg::TGT_W-1:0]  req_target_rotation,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [dsf_pkg::PIX_W-1:0]  rsp_pixel_x,
   output logic signed [dsf_pkg::PIX_W-1:0]  rsp_pixel_y,
   output logic [dsf_pkg::SCALE_W-1:0]       rsp_scale_now,
   output logic [dsf_pkg::SCALE_W-1:0]       rsp_angle_now,
   output logic                              rsp_settled
);
   import dsf_pkg::*;

   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        res_ff, res_in;
   result_type        result;
   ctrl_type          ctrl;
   status_type        status;
   logic              out_load, out_free;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   dsf_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .out_free  (out_free),
      .out_load  (out_load),
      .status    (status),
      .ctrl      (ctrl)
   );

   dsf_datapath #(
      .SNAP_THRESHOLD (SNAP_THRESHOLD),
      .DAMP_NUMERATOR (DAMP_NUMERATOR),
      .DAMP_SHIFT     (DAMP_SHIFT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .speed_gain      (gain_ff),
      .target_x        (req_target_x),
      .target_y        (req_target_y),
      .target_scale    (req_target_scale),
      .target_rotation (req_target_rotation),
      .status          (status),
      .result          (result)
   );

   always_comb begin
      gain_in      = (csr_valid && csr_ready) ? csr_speed_gain : gain_ff;
      res_in       = out_load ? result : res_ff;
      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_x   = res_ff.pixel_x;
   assign rsp_pixel_y   = res_ff.pixel_y;
   assign rsp_scale_now = res_ff.scale_now;
   assign rsp_angle_now = res_ff.angle_now;
   assign rsp_settled   = res_ff.settled;

endmodule

[rtl/core/dsf_checker.sv]
// Port-level checks for damped_spring_follower_top, attached by bind.
// Depends on dsf_pkg.
module dsf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [dsf_pkg::PIX_W-1:0]  rsp_pixel_x,
   input logic signed [dsf_pkg::PIX_W-1:0]  rsp_pixel_y,
   input logic [dsf_pkg::SCALE_W-1:0]       rsp_scale_now,
   input logic [dsf_pkg::SCALE_W-1:0]       rsp_angle_now,
   input logic                              rsp_settled
);
   import dsf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
         && $stable(rsp_scale_now) && $stable(rsp_angle_now) && $stable(rsp_settled))
      else $error("result changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready while a transaction is in flight");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after accept");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("outputs not cleared by reset");

endmodule

bind damped_spring_follower_top dsf_checker u_dsf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_pixel_x   (rsp_pixel_x),
   .rsp_pixel_y   (rsp_pixel_y),
   .rsp_scale_now (rsp_scale_now),
   .rsp_angle_now (rsp_angle_now),
   .rsp_settled   (rsp_settled)
);

[verif/damped_spring_follower_top_test.sv]
// Self-checking testbench for damped_spring_follower_top: predicts every frame result and
// checks it under random idling on both channels. Depends on dsf_pkg and the RTL only.
module damped_spring_follower_top_test;
   import dsf_pkg::*;

   localparam int SNAP_LIMIT   = 4;
   localparam int DAMP_MUL     = 179;
   localparam int DAMP_SH      = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 30;
   localparam int CHOKE_CYCLES = 400;
   localparam logic signed [TGT_W-1:0] TGT_MAX = {1'b0, {(TGT_W-1){1'b1}}};
   localparam logic signed [TGT_W-1:0] TGT_MIN = {1'b1, {(TGT_W-1){1'b0}}};

   typedef struct packed {
      logic signed [TGT_W-1:0] x;
      logic signed [TGT_W-1:0] y;
      logic [SCALE_W-1:0]      scale;
      logic signed [TGT_W-1:0] rot;
   } target_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [GAIN_W-1:0]         csr_speed_gain = GAIN_RESET;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [TGT_W-1:0]   req_target_x = '0;
   logic signed [TGT_W-1:0]   req_target_y = '0;
   logic [SCALE_W-1:0]        req_target_scale = '0;
   logic signed [TGT_W-1:0]   req_target_rotation = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [PIX_W-1:0]   rsp_pixel_x;
   logic signed [PIX_W-1:0]   rsp_pixel_y;
   logic [SCALE_W-1:0]        rsp_scale_now;
   logic [SCALE_W-1:0]        rsp_angle_now;
   logic                      rsp_settled;

   // predicted follower state
   logic [WORD_W-1:0] cur_x, cur_y, spd_x, spd_y;
   logic [WORD_W-1:0] cur_scale, spd_scale, cur_rot, spd_rot;
   logic [GAIN_W-1:0] gain_setting;

   target_type pending_targets[$];
   result_type expected_frames[$];
   target_type offered;
   result_type want, got;

   int  send_gap = 0;
   int  hold_left = 0;
   int  cycle_count = 0;
   int  error_count = 0;
   int  frames_checked = 0;
   int  settled_seen = 0;
   bit  quiet = 1'b0;
   bit  choke_armed = 1'b0;
   logic choke = 1'b0;

   damped_spring_follower_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_speed_gain      (csr_speed_gain),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_target_x        (req_target_x),
      .req_target_y        (req_target_y),
      .req_target_scale    (req_target_scale),
      .req_target_rotation (req_target_rotation),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pixel_x         (rsp_pixel_x),
      .rsp_pixel_y         (rsp_pixel_y),
      .rsp_scale_now       (rsp_scale_now),
      .rsp_angle_now       (rsp_angle_now),
      .rsp_settled         (rsp_settled)
   );

   always #2 clock = ~clock;

   // error / 8, truncated toward zero
   function automatic logic [WORD_W-1:0] eighth(input logic [WORD_W-1:0] u);
      if (u[WORD_W-1]) return 32'd0 - ((32'd0 - u) >> DIV_SHIFT);
      return u >> DIV_SHIFT;
   endfunction

   function automatic bit is_slow(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] mag;
      mag = v[WORD_W-1] ? 32'd0 - v : v;
      return mag < SNAP_LIMIT;
   endfunction

   function automatic logic [WORD_W-1:0] damped(input logic [WORD_W-1:0] v);
      logic signed [WORD_W-1:0] t;
      t = v * DAMP_MUL + (1 << (DAMP_SH - 1));
      return t >>> DAMP_SH;
   endfunction

   function automatic bit at_target(input logic [WORD_W-1:0] tx, ty, ts, tr);
      return spd_x == 0 && spd_y == 0 && spd_scale == 0 && spd_rot == 0 &&
             cur_x == tx && cur_y == ty && cur_scale == ts && cur_rot == tr;
   endfunction

   function automatic result_type spring_step(input target_type t);
      logic [WORD_W-1:0] tx, ty, ts, tr, ang;
      result_type r;
      tx = {{(WORD_W-TGT_W){t.x[TGT_W-1]}}, t.x};
      ty = {{(WORD_W-TGT_W){t.y[TGT_W-1]}}, t.y};
      ts = {{(WORD_W-SCALE_W){1'b0}}, t.scale};
      tr = {{(WORD_W-TGT_W){t.rot[TGT_W-1]}}, t.rot};
      if (!at_target(tx, ty, ts, tr)) begin
         spd_x = spd_x + eighth((tx - cur_x) * gain_setting);
         spd_y = spd_y + eighth((ty - cur_y) * gain_setting);
         spd_scale = spd_scale + eighth(ts - cur_scale);
         spd_rot = spd_rot + eighth(tr - cur_rot);
         if (is_slow(spd_x) && is_slow(spd_y)) begin
            spd_x = '0;
            spd_y = '0;
            cur_x = tx;
            cur_y = ty;
         end else begin
            spd_x = damped(spd_x);
            spd_y = damped(spd_y);
            cur_x = cur_x + spd_x;
            cur_y = cur_y + spd_y;
         end
         if (is_slow(spd_scale)) begin
            spd_scale = '0;
            cur_scale = ts;
         end else begin
            spd_scale = damped(spd_scale);
            cur_scale = cur_scale + spd_scale;
         end
         if (is_slow(spd_rot)) begin
            spd_rot = '0;
            cur_rot = tr;
         end else begin
            spd_rot = damped(spd_rot);
            cur_rot = cur_rot + spd_rot;
         end
      end
      ang = cur_rot - spd_x;
      r.pixel_x = cur_x[FRAC_BITS +: PIX_W];
      r.pixel_y = cur_y[FRAC_BITS +: PIX_W];
      r.scale_now = cur_scale[SCALE_W-1:0];
      r.angle_now = ang[SCALE_W-1:0];
      r.settled = at_target(tx, ty, ts, tr);
      return r;
   endfunction

   function automatic target_type pick_target(input target_type from);
      target_type n;
      n = from;
      case ($urandom_range(0, 4))
         0: begin
            n.x = TGT_W'($urandom);
            n.y = TGT_W'($urandom);
            n.scale = SCALE_W'($urandom);
            n.rot = TGT_W'($urandom);
         end
         1: begin
            n.x = TGT_W'(from.x + $urandom_range(0, 8191) - 4096);
            n.y = TGT_W'(from.y + $urandom_range(0, 8191) - 4096);
            n.scale = SCALE_W'($urandom_range(0, 1023));
         end
         2: begin
            n.scale = SCALE_W'(from.scale + $urandom_range(0, 63) - 32);
            n.rot = TGT_W'(from.rot + $urandom_range(0, 255) - 128);
         end
         3: begin
            n.x = $urandom_range(0, 1) ? TGT_MAX : TGT_MIN;
            n.y = $urandom_range(0, 1) ? TGT_MAX : TGT_MIN;
            n.scale = $urandom_range(0, 1) ? '1 : '0;
            n.rot = $urandom_range(0, 1) ? TGT_MAX : TGT_MIN;
         end
         default: begin
            // near misses around the snap threshold
            n.x = TGT_W'(from.x + $urandom_range(0, 63) - 32);
            n.y = TGT_W'(from.y + $urandom_range(0, 63) - 32);
            n.rot = TGT_W'(from.rot + $urandom_range(0, 63) - 32);
         end
      endcase
      return n;
   endfunction

   task automatic queue_target(input int x, y, s, r);
      target_type t;
      t.x = TGT_W'(x);
      t.y = TGT_W'(y);
      t.scale = SCALE_W'(s);
      t.rot = TGT_W'(r);
      pending_targets.push_back(t);
   endtask

   // mostly held targets so the spring settles, with some noise frames
   task automatic queue_random_targets(input int count);
      target_type base, t;
      int run;
      base = '{x: '0, y: '0, scale: 16'd256, rot: '0};
      run = 0;
      for (int i = 0; i < count; i++) begin
         if (run == 0) begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(10, 70);
            base = pick_target(base);
         end
         run--;
         t = base;
         if ($urandom_range(0, 11) == 0) begin
            t.x = TGT_W'($urandom);
            t.y = TGT_W'($urandom);
            t.scale = SCALE_W'($urandom);
            t.rot = TGT_W'($urandom);
         end
         pending_targets.push_back(t);
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] exp_v, act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   task automatic wait_idle();
      while (pending_targets.size() != 0 || req_valid || expected_frames.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_speed_gain(input logic [GAIN_W-1:0] g);
      wait_idle();
      csr_valid <= 1'b1;
      csr_speed_gain <= g;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      gain_setting = g;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_frames.push_back(spring_step(offered));
         if (!req_valid || req_ready) begin
            if (send_gap > 0 || pending_targets.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_valid <= 1'b0;
            end else begin
               offered = pending_targets.pop_front();
               req_valid <= 1'b1;
               req_target_x <= offered.x;
               req_target_y <= offered.y;
               req_target_scale <= offered.scale;
               req_target_rotation <= offered.rot;
               if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 10);
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            frames_checked++;
            if (expected_frames.size() == 0) begin
               $display("%0t: result with no transaction outstanding, actual %h %h %h %h %b",
                        $time, rsp_pixel_x, rsp_pixel_y, rsp_scale_now, rsp_angle_now,
                        rsp_settled);
               error_count++;
            end else begin
               want = expected_frames.pop_front();
               got = '{rsp_pixel_x, rsp_pixel_y, rsp_scale_now, rsp_angle_now, rsp_settled};
               compare_field("pixel_x", 16'(want.pixel_x), 16'(got.pixel_x));
               compare_field("pixel_y", 16'(want.pixel_y), 16'(got.pixel_y));
               compare_field("scale_now", want.scale_now, got.scale_now);
               compare_field("angle_now", want.angle_now, got.angle_now);
               compare_field("settled", 16'(want.settled), 16'(got.settled));
               if (want.settled) settled_seen++;
            end
         end
         if (hold_left > 0) hold_left--;
         else if (!quiet && $urandom_range(0, 7) == 0) hold_left = $urandom_range(1, 10);
         rsp_ready <= !choke && hold_left == 0;
      end
   end

   // long receiver stall so the block backs up into the request side
   initial begin
      wait (choke_armed);
      @(posedge clock);
      choke <= 1'b1;
      repeat (CHOKE_CYCLES) @(posedge clock);
      choke <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still outstanding", $time,
                  expected_frames.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      cur_x = '0;
      cur_y = '0;
      spd_x = '0;
      spd_y = '0;
      cur_scale = SCALE_RESET;
      spd_scale = '0;
      cur_rot = '0;
      spd_rot = '0;
      gain_setting = GAIN_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      set_speed_gain(4'd1);
      queue_target(0, 0, 256, 0);
      queue_target(24, -24, 280, 24);
      queue_target(24, -24, 280, 24);
      queue_target(56, -56, 312, 56);
      queue_target(56, -56, 312, 56);
      queue_target(TGT_MAX, TGT_MIN, 16'hFFFF, TGT_MAX);
      queue_target(TGT_MAX, TGT_MIN, 16'hFFFF, TGT_MAX);
      queue_target(TGT_MAX, TGT_MIN, 16'hFFFF, TGT_MAX);
      queue_target(TGT_MIN, TGT_MAX, 16'h0000, TGT_MIN);
      queue_target(TGT_MIN, TGT_MAX, 16'h0000, TGT_MIN);
      queue_target(TGT_MIN, TGT_MAX, 16'h0000, TGT_MIN);
      queue_target(-20, 20, 236, -20);
      queue_target(0, 0, 256, 0);
      queue_target(0, 0, 256, 0);

      set_speed_gain(4'd15);
      queue_random_targets(250);
      choke_armed = 1'b1;

      set_speed_gain(4'd0);
      queue_random_targets(150);

      set_speed_gain(4'd8);
      queue_random_targets(250);

      set_speed_gain(GAIN_W'($urandom_range(2, 14)));
      queue_random_targets(250);

      set_speed_gain(4'd1);
      queue_random_targets(300);

      set_speed_gain(4'd15);
      quiet = 1'b1;
      queue_random_targets(330);

      wait_idle();
      $display("Checked %0d frame results (%0d settled) across gains 0, 1, 8, 15 and one more,",
               frames_checked, settled_seen);
      $display("with idle bursts on both channels and one long result-side stall.");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/dsf_pkg.sv
rtl/core/dsf_sequencer.sv
rtl/core/dsf_datapath.sv
rtl/core/damped_spring_follower_top.sv
rtl/core/dsf_checker.sv
verif/damped_spring_follower_top_test.sv
